// ===== hw/rtl/uttp_pkg.sv =====
// Shared types and constants for the unlockable table transfer block.
// Holds the command codes, the password, the queue op codes and the state types.
// Depends on nothing; the queue, front, back and top files import it.
package uttp_pkg;

	localparam int TABLE_BYTES_DEF = 32;
	localparam int IDX_W           = 6;
	localparam int PASS_LEN        = 5;

	localparam logic [7:0] CMD_READ  = 8'h72;
	localparam logic [7:0] CMD_COUNT = 8'h71;
	localparam logic [7:0] CMD_WRITE = 8'h77;
	localparam logic [7:0] ACK_A     = 8'hAA;
	localparam logic [7:0] ACK_B     = 8'h55;

	typedef enum logic [1:0] {
		PH_LOCKED,
		PH_CMD,
		PH_RECEIVE
	} phase_t;

	typedef enum logic [1:0] {
		OP_DUMP,
		OP_COUNT,
		OP_ACK
	} op_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CNT_LO,
		B_CNT_HI,
		B_RD,
		B_DATA,
		B_SUM_LO,
		B_SUM_HI,
		B_COUNT
	} bstate_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [7:0]       data;
	} tbl_wr_t;

	function automatic logic [7:0] pass_byte(input logic [2:0] pos);
		logic [7:0] b;
		unique case (pos)
			3'd0:    b = 8'd2;
			3'd1:    b = 8'd6;
			3'd2:    b = 8'd2;
			3'd3:    b = 8'd1;
			3'd4:    b = 8'd9;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/uttp_rx_if.sv =====
// Receive channel: one serial byte per request, valid/ready handshake.
// Depends on nothing.
interface uttp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/uttp_tx_if.sv =====
// Transmit channel: one response byte per request with run and store marks.
// Depends on nothing.
interface uttp_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;
	logic       store_request;

	modport source (output valid, output tx_byte, output last, output store_request,
		input ready);
	modport sink (input valid, input tx_byte, input last, input store_request,
		output ready);
endinterface

// ===== hw/rtl/uttp_queue.sv =====
// Two-entry op queue between the front and the back part.
// Depends on uttp_pkg for the op type.
module uttp_queue
	import uttp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head_op,
	output logic empty,
	output logic full
);

	op_t        ent_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign head_op = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hw/rtl/uttp_front.sv =====
// Front part: accepts received bytes, tracks the password, command and receive
// phases, writes staging bytes and checks the checksum. Depends on uttp_pkg.
module uttp_front
	import uttp_pkg::*;
#(
	parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	uttp_rx_if.sink rx,
	input  logic    q_full,
	input  logic    back_idle,
	output logic    push,
	output op_t     push_op,
	output tbl_wr_t wr
);

	localparam logic [5:0] CNT = 6'(TABLE_BYTES);

	phase_t      phase_q, phase_d;
	logic [5:0]  prog_q, prog_d;
	logic [15:0] dsum_q, dsum_d;
	logic [7:0]  rsum_lo_q, rsum_lo_d;
	logic        stall;
	logic        acc;

	// Staging writes wait until the back part has settled its bank choice.
	assign stall    = (phase_q == PH_RECEIVE) && (prog_q < CNT) && !back_idle;
	assign rx.ready = !q_full && !stall;
	assign acc      = rx.valid && rx.ready;

	always_comb begin
		phase_d   = phase_q;
		prog_d    = prog_q;
		dsum_d    = dsum_q;
		rsum_lo_d = rsum_lo_q;
		push      = 1'b0;
		push_op   = OP_COUNT;
		wr.en     = 1'b0;
		wr.idx    = prog_q;
		wr.data   = rx.rx_byte;
		if (acc) begin
			unique case (phase_q)
				PH_CMD: begin
					if (rx.rx_byte == CMD_READ) begin
						push    = 1'b1;
						push_op = OP_DUMP;
						phase_d = PH_LOCKED;
						prog_d  = 6'd0;
					end else if (rx.rx_byte == CMD_WRITE) begin
						phase_d = PH_RECEIVE;
						prog_d  = 6'd0;
						dsum_d  = 16'd0;
					end else if (rx.rx_byte == CMD_COUNT) begin
						push    = 1'b1;
						push_op = OP_COUNT;
						phase_d = PH_LOCKED;
						prog_d  = 6'd0;
					end
				end
				PH_RECEIVE: begin
					prog_d = prog_q + 6'd1;
					if (prog_q < CNT) begin
						wr.en  = 1'b1;
						dsum_d = dsum_q + {8'd0, rx.rx_byte};
					end else if (prog_q == CNT) begin
						rsum_lo_d = rx.rx_byte;
					end else begin
						if ({rx.rx_byte, rsum_lo_q} == dsum_q) begin
							push    = 1'b1;
							push_op = OP_ACK;
						end
						phase_d = PH_LOCKED;
						prog_d  = 6'd0;
					end
				end
				default: begin
					phase_d = PH_LOCKED;
					if (prog_q < 6'(PASS_LEN) && rx.rx_byte == pass_byte(prog_q[2:0])) begin
						prog_d = prog_q + 6'd1;
					end else begin
						prog_d = 6'd0;
					end
					if (prog_d == 6'(PASS_LEN)) begin
						phase_d = PH_CMD;
						prog_d  = 6'd0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOCKED;
			prog_q  <= 6'd0;
		end else begin
			phase_q <= phase_d;
			prog_q  <= prog_d;
		end
	end

	always_ff @(posedge clk) begin
		dsum_q    <= dsum_d;
		rsum_lo_q <= rsum_lo_d;
	end

endmodule

// ===== hw/rtl/uttp_back.sv =====
// Back part: holds the two-bank table memory, runs dump, count and acknowledge
// responses and drives the transmit register. Depends on uttp_pkg.
module uttp_back
	import uttp_pkg::*;
#(
	parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tbl_wr_t     wr,
	input  op_t         head_op,
	input  logic        q_empty,
	output logic        pop,
	output logic        idle,
	uttp_tx_if.source   tx
);

	localparam int         IW     = $clog2(TABLE_BYTES);
	localparam int         DEPTH  = 2 ** (IW + 1);
	localparam logic [7:0] CNT_LO = 8'(TABLE_BYTES);
	localparam logic [7:0] CNT_HI = 8'(TABLE_BYTES >> 8);
	localparam logic [7:0] CNT_8  = 8'(TABLE_BYTES / 8);
	localparam logic [IW-1:0] IDX_END = IW'(TABLE_BYTES - 1);
	localparam logic [IW-1:0] ACK_END = IW'(3);

	logic [7:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]    rd_q;
	logic          rv_q;

	bstate_t       st_q, st_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [15:0]   sum_q, sum_d;
	logic          bank_q, bank_d;
	logic          ack_q, ack_d;

	logic          rd_en;
	logic [IW:0]   rd_addr;
	logic [IW:0]   wr_addr;
	logic          can;
	logic          ld;
	logic [7:0]    ld_byte;
	logic          ld_last;
	logic          ld_store;
	logic [7:0]    rdata;

	logic [7:0]    tx_q;
	logic          last_q;
	logic          store_q;
	logic          ov_q;

	assign wr_addr = {~bank_q, wr.idx[IW-1:0]};
	assign rd_addr = {bank_q, idx_q};
	assign rdata   = rv_q ? rd_q : 8'd0;
	assign can     = !ov_q || tx.ready;
	assign idle    = (st_q == B_IDLE) && !ack_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
			rv_q <= vld_q[rd_addr];
		end
	end

	// Entries never written read as zero, which covers the cleared committed table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_comb begin
		st_d     = st_q;
		idx_d    = idx_q;
		sum_d    = sum_q;
		bank_d   = bank_q;
		ack_d    = ack_q;
		pop      = 1'b0;
		rd_en    = 1'b0;
		ld       = 1'b0;
		ld_byte  = 8'd0;
		ld_last  = 1'b0;
		ld_store = 1'b0;
		if (ack_q) begin
			if (can) begin
				ld      = 1'b1;
				ld_byte = idx_q[0] ? ACK_B : ACK_A;
				idx_d   = idx_q + IW'(1);
				if (idx_q == ACK_END) begin
					ld_last  = 1'b1;
					ld_store = 1'b1;
					ack_d    = 1'b0;
				end
			end
		end else begin
			unique case (st_q)
				B_IDLE: begin
					if (!q_empty) begin
						pop   = 1'b1;
						idx_d = '0;
						sum_d = 16'd0;
						unique case (head_op)
							OP_DUMP:  st_d = B_CNT_LO;
							OP_ACK: begin
								ack_d  = 1'b1;
								bank_d = ~bank_q;
							end
							default:  st_d = B_COUNT;
						endcase
					end
				end
				B_CNT_LO: begin
					if (can) begin
						ld      = 1'b1;
						ld_byte = CNT_LO;
						sum_d   = sum_q + {8'd0, CNT_LO};
						st_d    = B_CNT_HI;
					end
				end
				B_CNT_HI: begin
					if (can) begin
						ld      = 1'b1;
						ld_byte = CNT_HI;
						sum_d   = sum_q + {8'd0, CNT_HI};
						st_d    = B_RD;
					end
				end
				B_RD: begin
					rd_en = 1'b1;
					st_d  = B_DATA;
				end
				B_DATA: begin
					if (can) begin
						ld      = 1'b1;
						ld_byte = rdata;
						sum_d   = sum_q + {8'd0, rdata};
						if (idx_q == IDX_END) begin
							st_d = B_SUM_LO;
						end else begin
							idx_d = idx_q + IW'(1);
							st_d  = B_RD;
						end
					end
				end
				B_SUM_LO: begin
					if (can) begin
						ld      = 1'b1;
						ld_byte = sum_q[7:0];
						st_d    = B_SUM_HI;
					end
				end
				B_SUM_HI: begin
					if (can) begin
						ld      = 1'b1;
						ld_byte = sum_q[15:8];
						ld_last = 1'b1;
						st_d    = B_IDLE;
					end
				end
				B_COUNT: begin
					if (can) begin
						ld      = 1'b1;
						ld_byte = CNT_8;
						ld_last = 1'b1;
						st_d    = B_IDLE;
					end
				end
				default: st_d = B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			bank_q <= 1'b0;
			ack_q  <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			bank_q <= bank_d;
			ack_q  <= ack_d;
			if (ld) begin
				ov_q <= 1'b1;
			end else if (tx.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		sum_q <= sum_d;
		if (ld) begin
			tx_q    <= ld_byte;
			last_q  <= ld_last;
			store_q <= ld_store;
		end
	end

	assign tx.valid         = ov_q;
	assign tx.tx_byte       = tx_q;
	assign tx.last          = last_q;
	assign tx.store_request = store_q;

endmodule

// ===== hw/rtl/unlocked_table_transfer_protocol.sv =====
// Top level of the unlockable table transfer block: front, op queue and back.
// Depends on uttp_pkg, uttp_rx_if, uttp_tx_if, uttp_queue, uttp_front, uttp_back.
//
// The block takes one received byte per request and answers with runs of
// transmit bytes. For a table dump the back part reads the table memory one
// byte at a time, with a read state before each data byte. A two-entry op
// queue lets the front keep taking bytes while the back part answers; staging
// data bytes wait only while an earlier response is still being run. The
// committed and staging tables are two banks of one memory, and a commit
// swaps them, so no copy pass is needed.
// After reset the committed table reads as zero at once; there is no clearing pass.
module unlocked_table_transfer_protocol
	import uttp_pkg::*;
#(
	parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	uttp_rx_if.sink   rx,
	uttp_tx_if.source tx
);

	logic    q_push;
	op_t     q_push_op;
	logic    q_pop;
	op_t     q_head;
	logic    q_empty;
	logic    q_full;
	logic    back_idle;
	logic    front_idle;
	tbl_wr_t wr;

	assign front_idle = back_idle && q_empty;

	uttp_front #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.q_full    (q_full),
		.back_idle (front_idle),
		.push      (q_push),
		.push_op   (q_push_op),
		.wr        (wr)
	);

	uttp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_push_op),
		.pop     (q_pop),
		.head_op (q_head),
		.empty   (q_empty),
		.full    (q_full)
	);

	uttp_back #(
		.TABLE_BYTES(TABLE_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.head_op (q_head),
		.q_empty (q_empty),
		.pop     (q_pop),
		.idle    (back_idle),
		.tx      (tx)
	);

endmodule
